[hw/rtl/lbsm_pkg.sv]
package lbsm_pkg;

   // Field and register widths
   localparam int CELL_W   = 8;
   localparam int OFF_W    = 5;
   localparam int LOCAL_W  = 6;
   localparam int SIZE_W   = 9;
   localparam int LAYER_W  = 17;
   localparam int BASIS_W  = 7;
   localparam int PMASK_W  = 3;
   localparam int SITE_W   = 30;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 17;
   localparam int DIMS     = 3;

   // Sum of cell index and offset, signed, with room for both ends of its range
   localparam int SUM_W    = CELL_W + 2;

   // Largest value a size register can hold
   localparam int SIZE_MAX = (1 << SIZE_W) - 1;

   // Default extent limit
   localparam int MAX_EXTENT_DEF = 256;

   // Restoring divider: one quotient bit per step
   localparam int DIV_STEPS = SIZE_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SIZE_X      = 3'd0,
      CSR_SIZE_Y      = 3'd1,
      CSR_SIZE_Z      = 3'd2,
      CSR_LAYER_CELLS = 3'd3,
      CSR_PERIODIC    = 3'd4,
      CSR_BASIS       = 3'd5
   } csr_index_type;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_OFFSET = 8'b0000_0010,
      ST_DIVIDE = 8'b0000_0100,
      ST_ROW    = 8'b0000_1000,
      ST_LAYER  = 8'b0001_0000,
      ST_SITE   = 8'b0010_0000,
      ST_STORE  = 8'b0100_0000,
      ST_FINISH = 8'b1000_0000
   } state_type;

   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

[hw/rtl/lbsm_divider.sv]
module lbsm_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  lbsm_pkg::div_ctrl_type         ctrl,
   input  logic [lbsm_pkg::SIZE_W-1:0]    dividend,
   input  logic [lbsm_pkg::SIZE_W-1:0]    divisor,
   output lbsm_pkg::div_status_type       status,
   output logic [lbsm_pkg::SIZE_W-1:0]    quotient,
   output logic [lbsm_pkg::SIZE_W-1:0]    remainder
);

   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [lbsm_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [lbsm_pkg::SIZE_W-1:0]      dvd_ff, dvd_in;
   logic [lbsm_pkg::SIZE_W-1:0]      rem_ff, rem_in;
   logic [lbsm_pkg::SIZE_W-1:0]      dsr_ff, dsr_in;
   logic [lbsm_pkg::SIZE_W:0]        trial;
   logic                             fits;

   // Shift in the next dividend bit and try to subtract the divisor
   assign trial = {rem_ff, dvd_ff[lbsm_pkg::SIZE_W-1]};
   assign fits  = (trial >= {1'b0, dsr_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (ctrl.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = lbsm_pkg::SIZE_W'(trial - {1'b0, dsr_ff});
         end else begin
            rem_in = trial[lbsm_pkg::SIZE_W-1:0];
         end
         dvd_in = {dvd_ff[lbsm_pkg::SIZE_W-2:0], fits};
         if (cnt_ff == lbsm_pkg::DIV_CNT_W'(lbsm_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = dvd_ff;
   assign remainder   = rem_ff;

endmodule

[hw/rtl/lbsm_mac.sv]
module lbsm_mac (
   input  logic                           clock,
   input  logic                           enable,
   input  logic [lbsm_pkg::SITE_W-1:0]    addend,
   input  logic [lbsm_pkg::SITE_W-1:0]    mult_a,
   input  logic [lbsm_pkg::LAYER_W-1:0]   mult_b,
   output logic [lbsm_pkg::SITE_W-1:0]    acc
);

   logic [lbsm_pkg::SITE_W+lbsm_pkg::LAYER_W-1:0] prod;
   logic [lbsm_pkg::SITE_W-1:0]                   acc_ff, acc_in;

   // Everything downstream is taken modulo 2**SITE_W, so drop the high product bits
   assign prod   = mult_a * mult_b;
   assign acc_in = addend + prod[lbsm_pkg::SITE_W-1:0];

   always_ff @(posedge clock) begin
      if (enable) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

[hw/rtl/lattice_bond_site_mapper.sv]
// Lattice bond site mapper: turns one bond (a unit cell and two endpoint offsets)
// into two global site numbers under periodic or open boundaries.
//
// Channels: the req_ channel carries one bond per transfer; the rsp_ channel
// returns exactly one result per bond, in order. Both use valid/ready.
// The csr_ port writes the six lattice registers, one register per write; write it
// only while no bond is in flight and no result is pending.
//
// Sequencing: each endpoint walks the three dimensions; every dimension that
// wraps uses the shared 9-step restoring divider. A bond that exits an open
// dimension finishes early. The multiply-add unit runs three steps per endpoint:
// row, layer, site. req_ready is high only while the sequencer idles, so the next
// bond is taken only once the last one's result is loaded into the output register.
//
// Reset clears the sequencer and the result valid flag, and sets the registers to
// their defaults (sizes 1, no periodic dimension, one basis site).
// A stalled receiver holds the result in the output register; the next bond is
// still taken and computed, and waits in its last state until the register frees.
module lattice_bond_site_mapper #(
   parameter int MAX_EXTENT = lbsm_pkg::MAX_EXTENT_DEF
) (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [lbsm_pkg::CELL_W-1:0]        req_cell_x,
   input  logic [lbsm_pkg::CELL_W-1:0]        req_cell_y,
   input  logic [lbsm_pkg::CELL_W-1:0]        req_cell_z,
   input  logic signed [lbsm_pkg::OFF_W-1:0]  req_src_dx,
   input  logic signed [lbsm_pkg::OFF_W-1:0]  req_src_dy,
   input  logic signed [lbsm_pkg::OFF_W-1:0]  req_src_dz,
   input  logic [lbsm_pkg::LOCAL_W-1:0]       req_src_local,
   input  logic signed [lbsm_pkg::OFF_W-1:0]  req_tgt_dx,
   input  logic signed [lbsm_pkg::OFF_W-1:0]  req_tgt_dy,
   input  logic signed [lbsm_pkg::OFF_W-1:0]  req_tgt_dz,
   input  logic [lbsm_pkg::LOCAL_W-1:0]       req_tgt_local,

   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_connected,
   output logic [lbsm_pkg::SITE_W-1:0]        rsp_src_site,
   output logic [lbsm_pkg::SITE_W-1:0]        rsp_tgt_site,
   output logic                               rsp_flip_x,
   output logic                               rsp_flip_y,
   output logic                               rsp_flip_z,
   output logic [lbsm_pkg::DIMS-1:0]          rsp_src_outside,
   output logic [lbsm_pkg::DIMS-1:0]          rsp_tgt_outside,

   input  logic                               csr_write_en,
   input  logic [lbsm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lbsm_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   // Sizes above the extent limit clamp to it; the 9-bit register caps it anyway
   localparam logic [lbsm_pkg::SIZE_W-1:0] SIZE_CLAMP =
      lbsm_pkg::SIZE_W'((MAX_EXTENT > lbsm_pkg::SIZE_MAX) ? lbsm_pkg::SIZE_MAX : MAX_EXTENT);

   // Lattice registers
   logic [lbsm_pkg::SIZE_W-1:0]    size_x_ff, size_y_ff, size_z_ff;
   logic [lbsm_pkg::LAYER_W-1:0]   layer_ff;
   logic [lbsm_pkg::PMASK_W-1:0]   periodic_ff;
   logic [lbsm_pkg::BASIS_W-1:0]   basis_ff;

   // Sequencer
   lbsm_pkg::state_type            state_ff, state_in;
   logic                           ep_ff, ep_in;
   logic [1:0]                     dim_ff, dim_in;

   // Working copy of the bond
   logic [lbsm_pkg::DIMS-1:0][lbsm_pkg::CELL_W-1:0]       cell_ff, cell_in;
   logic [1:0][lbsm_pkg::DIMS-1:0][lbsm_pkg::OFF_W-1:0]   off_ff, off_in;
   logic [1:0][lbsm_pkg::LOCAL_W-1:0]                     local_ff, local_in;

   // Per-endpoint results
   logic [lbsm_pkg::DIMS-1:0][lbsm_pkg::SIZE_W-1:0]       idx_ff, idx_in;
   logic [1:0][lbsm_pkg::DIMS-1:0]                        flip_ff, flip_in;
   logic [1:0][lbsm_pkg::DIMS-1:0]                        outside_ff, outside_in;
   logic [1:0][lbsm_pkg::SITE_W-1:0]                      site_ff, site_in;
   logic                                                  conn_ff, conn_in;
   logic                                                  neg_ff, neg_in;

   // Result register
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                rsp_conn_ff, rsp_conn_in;
   logic [lbsm_pkg::SITE_W-1:0]         rsp_src_site_ff, rsp_src_site_in;
   logic [lbsm_pkg::SITE_W-1:0]         rsp_tgt_site_ff, rsp_tgt_site_in;
   logic [lbsm_pkg::DIMS-1:0]           rsp_flip_ff, rsp_flip_in;
   logic [lbsm_pkg::DIMS-1:0]           rsp_src_out_ff, rsp_src_out_in;
   logic [lbsm_pkg::DIMS-1:0]           rsp_tgt_out_ff, rsp_tgt_out_in;

   // Effective sizes and the current dimension's sum
   logic [lbsm_pkg::DIMS-1:0][lbsm_pkg::SIZE_W-1:0] eff_size;
   logic [lbsm_pkg::SIZE_W-1:0]                     cur_size;
   logic [lbsm_pkg::OFF_W-1:0]                      cur_off;
   logic signed [lbsm_pkg::SUM_W-1:0]               sum;
   logic                                            sum_neg;
   logic [lbsm_pkg::SUM_W-1:0]                      sum_abs;
   logic [lbsm_pkg::SIZE_W-1:0]                     sum_mag;
   logic                                            in_range;

   // Shared units
   lbsm_pkg::div_ctrl_type              div_ctrl;
   lbsm_pkg::div_status_type            div_status;
   logic [lbsm_pkg::SIZE_W-1:0]         div_quot, div_rem;
   logic                                mac_en;
   logic [lbsm_pkg::SITE_W-1:0]         mac_addend, mac_a, mac_acc;
   logic [lbsm_pkg::LAYER_W-1:0]        mac_b;

   logic                                load_rsp;

   // A zero size counts as one, a size above the limit as the limit
   always_comb begin
      eff_size[0] = size_x_ff;
      eff_size[1] = size_y_ff;
      eff_size[2] = size_z_ff;
      for (int d = 0; d < lbsm_pkg::DIMS; d++) begin
         if (eff_size[d] == '0) begin
            eff_size[d] = lbsm_pkg::SIZE_W'(1);
         end else if (eff_size[d] > SIZE_CLAMP) begin
            eff_size[d] = SIZE_CLAMP;
         end
      end
   end

   assign cur_size = eff_size[dim_ff];
   assign cur_off  = off_ff[ep_ff][dim_ff];
   assign sum      = $signed({2'b00, cell_ff[dim_ff]})
                   + $signed({{(lbsm_pkg::SUM_W-lbsm_pkg::OFF_W){cur_off[lbsm_pkg::OFF_W-1]}},
                              cur_off});
   assign sum_neg  = sum[lbsm_pkg::SUM_W-1];
   assign sum_abs  = sum_neg ? lbsm_pkg::SUM_W'(-sum) : lbsm_pkg::SUM_W'(sum);
   assign sum_mag  = sum_abs[lbsm_pkg::SIZE_W-1:0];
   assign in_range = !sum_neg && (sum_mag < cur_size);

   lbsm_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (div_ctrl),
      .dividend  (sum_mag),
      .divisor   (cur_size),
      .status    (div_status),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   lbsm_mac u_mac (
      .clock  (clock),
      .enable (mac_en),
      .addend (mac_addend),
      .mult_a (mac_a),
      .mult_b (mac_b),
      .acc    (mac_acc)
   );

   assign req_ready = (state_ff == lbsm_pkg::ST_IDLE);
   assign load_rsp  = (state_ff == lbsm_pkg::ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   // Sequencer: walk dimensions (dividing where one wraps), then row, layer and site steps, per endpoint
   always_comb begin
      state_in      = state_ff;
      ep_in         = ep_ff;
      dim_in        = dim_ff;
      cell_in       = cell_ff;
      off_in        = off_ff;
      local_in      = local_ff;
      idx_in        = idx_ff;
      flip_in       = flip_ff;
      outside_in    = outside_ff;
      site_in       = site_ff;
      conn_in       = conn_ff;
      neg_in        = neg_ff;
      div_ctrl      = '0;
      mac_en        = 1'b0;
      mac_addend    = '0;
      mac_a         = '0;
      mac_b         = '0;

      unique case (state_ff)
         lbsm_pkg::ST_IDLE: begin
            if (req_valid) begin
               cell_in[0]  = req_cell_x;
               cell_in[1]  = req_cell_y;
               cell_in[2]  = req_cell_z;
               off_in[0][0] = req_src_dx;
               off_in[0][1] = req_src_dy;
               off_in[0][2] = req_src_dz;
               off_in[1][0] = req_tgt_dx;
               off_in[1][1] = req_tgt_dy;
               off_in[1][2] = req_tgt_dz;
               local_in[0] = req_src_local;
               local_in[1] = req_tgt_local;
               flip_in     = '0;
               outside_in  = '0;
               conn_in     = 1'b1;
               ep_in       = 1'b0;
               dim_in      = '0;
               state_in    = lbsm_pkg::ST_OFFSET;
            end
         end

         lbsm_pkg::ST_OFFSET: begin
            if (in_range) begin
               idx_in[dim_ff] = sum_mag;
               if (dim_ff == 2'(lbsm_pkg::DIMS - 1)) begin
                  dim_in   = '0;
                  state_in = lbsm_pkg::ST_ROW;
               end else begin
                  dim_in   = dim_ff + 1'b1;
               end
            end else if (!periodic_ff[dim_ff]) begin
               // Open boundary crossed: the bond is not connected
               conn_in  = 1'b0;
               state_in = lbsm_pkg::ST_FINISH;
            end else begin
               outside_in[ep_ff][dim_ff] = 1'b1;
               neg_in         = sum_neg;
               div_ctrl.start = 1'b1;
               state_in       = lbsm_pkg::ST_DIVIDE;
            end
         end

         lbsm_pkg::ST_DIVIDE: begin
            if (div_status.done) begin
               if (!neg_ff) begin
                  idx_in[dim_ff] = div_rem;
                  flip_in[ep_ff][dim_ff] = div_quot[0];
               end else if (div_rem == '0) begin
                  // Below zero by an exact multiple of the size
                  idx_in[dim_ff] = '0;
                  flip_in[ep_ff][dim_ff] = div_quot[0];
               end else begin
                  idx_in[dim_ff] = cur_size - div_rem;
                  flip_in[ep_ff][dim_ff] = !div_quot[0];
               end
               if (dim_ff == 2'(lbsm_pkg::DIMS - 1)) begin
                  dim_in   = '0;
                  state_in = lbsm_pkg::ST_ROW;
               end else begin
                  dim_in   = dim_ff + 1'b1;
                  state_in = lbsm_pkg::ST_OFFSET;
               end
            end
         end

         lbsm_pkg::ST_ROW: begin
            mac_en     = 1'b1;
            mac_addend = lbsm_pkg::SITE_W'(idx_ff[0]);
            mac_a      = lbsm_pkg::SITE_W'(idx_ff[1]);
            mac_b      = lbsm_pkg::LAYER_W'(eff_size[0]);
            state_in   = lbsm_pkg::ST_LAYER;
         end

         lbsm_pkg::ST_LAYER: begin
            mac_en     = 1'b1;
            mac_addend = mac_acc;
            mac_a      = lbsm_pkg::SITE_W'(idx_ff[2]);
            mac_b      = layer_ff;
            state_in   = lbsm_pkg::ST_SITE;
         end

         lbsm_pkg::ST_SITE: begin
            mac_en     = 1'b1;
            mac_addend = lbsm_pkg::SITE_W'(local_ff[ep_ff]);
            mac_a      = mac_acc;
            mac_b      = lbsm_pkg::LAYER_W'(basis_ff);
            state_in   = lbsm_pkg::ST_STORE;
         end

         lbsm_pkg::ST_STORE: begin
            site_in[ep_ff] = mac_acc;
            if (!ep_ff) begin
               ep_in    = 1'b1;
               dim_in   = '0;
               state_in = lbsm_pkg::ST_OFFSET;
            end else begin
               state_in = lbsm_pkg::ST_FINISH;
            end
         end

         lbsm_pkg::ST_FINISH: begin
            if (load_rsp) begin
               state_in = lbsm_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = lbsm_pkg::ST_IDLE;
         end
      endcase
   end

   // Result register: load when free or draining in the same cycle
   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_conn_in     = rsp_conn_ff;
      rsp_src_site_in = rsp_src_site_ff;
      rsp_tgt_site_in = rsp_tgt_site_ff;
      rsp_flip_in     = rsp_flip_ff;
      rsp_src_out_in  = rsp_src_out_ff;
      rsp_tgt_out_in  = rsp_tgt_out_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_conn_in  = conn_ff;
         if (conn_ff) begin
            rsp_src_site_in = site_ff[0];
            rsp_tgt_site_in = site_ff[1];
            rsp_flip_in     = flip_ff[0] ^ flip_ff[1];
            rsp_src_out_in  = outside_ff[0];
            rsp_tgt_out_in  = outside_ff[1];
         end else begin
            // Unconnected bond: every field but the flag reads zero
            rsp_src_site_in = '0;
            rsp_tgt_site_in = '0;
            rsp_flip_in     = '0;
            rsp_src_out_in  = '0;
            rsp_tgt_out_in  = '0;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lbsm_pkg::ST_IDLE;
         ep_ff        <= 1'b0;
         dim_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         size_x_ff    <= lbsm_pkg::SIZE_W'(1);
         size_y_ff    <= lbsm_pkg::SIZE_W'(1);
         size_z_ff    <= lbsm_pkg::SIZE_W'(1);
         layer_ff     <= lbsm_pkg::LAYER_W'(1);
         periodic_ff  <= '0;
         basis_ff     <= lbsm_pkg::BASIS_W'(1);
      end else begin
         state_ff     <= state_in;
         ep_ff        <= ep_in;
         dim_ff       <= dim_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            unique case (csr_index)
               lbsm_pkg::CSR_SIZE_X:      size_x_ff   <= csr_wdata[lbsm_pkg::SIZE_W-1:0];
               lbsm_pkg::CSR_SIZE_Y:      size_y_ff   <= csr_wdata[lbsm_pkg::SIZE_W-1:0];
               lbsm_pkg::CSR_SIZE_Z:      size_z_ff   <= csr_wdata[lbsm_pkg::SIZE_W-1:0];
               lbsm_pkg::CSR_LAYER_CELLS: layer_ff    <= csr_wdata[lbsm_pkg::LAYER_W-1:0];
               lbsm_pkg::CSR_PERIODIC:    periodic_ff <= csr_wdata[lbsm_pkg::PMASK_W-1:0];
               lbsm_pkg::CSR_BASIS:       basis_ff    <= csr_wdata[lbsm_pkg::BASIS_W-1:0];
               default: begin
                  // Drop writes to unused indexes
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cell_ff         <= cell_in;
      off_ff          <= off_in;
      local_ff        <= local_in;
      idx_ff          <= idx_in;
      flip_ff         <= flip_in;
      outside_ff      <= outside_in;
      site_ff         <= site_in;
      conn_ff         <= conn_in;
      neg_ff          <= neg_in;
      rsp_conn_ff     <= rsp_conn_in;
      rsp_src_site_ff <= rsp_src_site_in;
      rsp_tgt_site_ff <= rsp_tgt_site_in;
      rsp_flip_ff     <= rsp_flip_in;
      rsp_src_out_ff  <= rsp_src_out_in;
      rsp_tgt_out_ff  <= rsp_tgt_out_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_connected   = rsp_conn_ff;
   assign rsp_src_site    = rsp_src_site_ff;
   assign rsp_tgt_site    = rsp_tgt_site_ff;
   assign rsp_flip_x      = rsp_flip_ff[0];
   assign rsp_flip_y      = rsp_flip_ff[1];
   assign rsp_flip_z      = rsp_flip_ff[2];
   assign rsp_src_outside = rsp_src_out_ff;
   assign rsp_tgt_outside = rsp_tgt_out_ff;

   // The divider reports completion only to a sequencer that waits for it
   assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == lbsm_pkg::ST_DIVIDE))
      else $error("divider finished outside the divide state");

   // No new bond while the divider still works on the last one
   assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !div_status.busy)
      else $error("ready while the divider is busy");

   // An unconnected result carries no site numbers and no offsets
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_connected) |->
         (rsp_src_site == '0) && (rsp_tgt_site == '0) &&
         (rsp_src_outside == '0) && (rsp_tgt_outside == '0))
      else $error("unconnected result with nonzero fields");

   // Only periodic dimensions can keep an offset
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_src_outside & ~periodic_ff) == '0) &&
                    ((rsp_tgt_outside & ~periodic_ff) == '0))
      else $error("offset kept in an open dimension");

endmodule

[tb/sv/tb_lattice_bond_site_mapper.sv]
`timescale 1ns / 1ps

module tb_lattice_bond_site_mapper;

   // One bond as the sender sees it; index 0 of each array is the x dimension
   typedef struct packed {
      logic [lbsm_pkg::DIMS-1:0][lbsm_pkg::CELL_W-1:0] cells;
      logic [lbsm_pkg::DIMS-1:0][lbsm_pkg::OFF_W-1:0]  src_off;
      logic [lbsm_pkg::DIMS-1:0][lbsm_pkg::OFF_W-1:0]  tgt_off;
      logic [lbsm_pkg::LOCAL_W-1:0]                    src_local;
      logic [lbsm_pkg::LOCAL_W-1:0]                    tgt_local;
   } bond_type;

   // One mapped bond; flip bit 0 is x
   typedef struct packed {
      logic                        connected;
      logic [lbsm_pkg::SITE_W-1:0] src_site;
      logic [lbsm_pkg::SITE_W-1:0] tgt_site;
      logic [lbsm_pkg::DIMS-1:0]   flip;
      logic [lbsm_pkg::DIMS-1:0]   src_outside;
      logic [lbsm_pkg::DIMS-1:0]   tgt_outside;
   } site_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                               req_valid = 1'b0;
   logic                               req_ready;
   logic [lbsm_pkg::CELL_W-1:0]        req_cell_x = '0;
   logic [lbsm_pkg::CELL_W-1:0]        req_cell_y = '0;
   logic [lbsm_pkg::CELL_W-1:0]        req_cell_z = '0;
   logic signed [lbsm_pkg::OFF_W-1:0]  req_src_dx = '0;
   logic signed [lbsm_pkg::OFF_W-1:0]  req_src_dy = '0;
   logic signed [lbsm_pkg::OFF_W-1:0]  req_src_dz = '0;
   logic [lbsm_pkg::LOCAL_W-1:0]       req_src_local = '0;
   logic signed [lbsm_pkg::OFF_W-1:0]  req_tgt_dx = '0;
   logic signed [lbsm_pkg::OFF_W-1:0]  req_tgt_dy = '0;
   logic signed [lbsm_pkg::OFF_W-1:0]  req_tgt_dz = '0;
   logic [lbsm_pkg::LOCAL_W-1:0]       req_tgt_local = '0;

   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   logic                               rsp_connected;
   logic [lbsm_pkg::SITE_W-1:0]        rsp_src_site;
   logic [lbsm_pkg::SITE_W-1:0]        rsp_tgt_site;
   logic                               rsp_flip_x;
   logic                               rsp_flip_y;
   logic                               rsp_flip_z;
   logic [lbsm_pkg::DIMS-1:0]          rsp_src_outside;
   logic [lbsm_pkg::DIMS-1:0]          rsp_tgt_outside;

   logic                               csr_write_en = 1'b0;
   logic [lbsm_pkg::CSR_IDX_W-1:0]     csr_index = '0;
   logic [lbsm_pkg::CSR_DATA_W-1:0]    csr_wdata = '0;

   // Shadow copy of the lattice registers, at their reset values
   logic [lbsm_pkg::DIMS-1:0][lbsm_pkg::SIZE_W-1:0] cfg_size =
      {lbsm_pkg::SIZE_W'(1), lbsm_pkg::SIZE_W'(1), lbsm_pkg::SIZE_W'(1)};
   logic [lbsm_pkg::LAYER_W-1:0]  cfg_layer = lbsm_pkg::LAYER_W'(1);
   logic [lbsm_pkg::PMASK_W-1:0]  cfg_periodic = '0;
   logic [lbsm_pkg::BASIS_W-1:0]  cfg_basis = lbsm_pkg::BASIS_W'(1);

   // Mapped bonds waiting for their result transfer, oldest first
   site_result_type pending_sites[$];
   site_result_type rsp_seen;
   site_result_type rsp_want;

   int idle_pct = 0;      // chance in percent that the sender skips a cycle
   int stall_pct = 0;     // chance in percent that the receiver stalls
   int hold_left = 0;     // cycles the receiver still holds off, whatever stall_pct says

   int mismatch_count = 0;
   int bonds_sent = 0;
   int lattice_count = 0;
   int connected_count = 0;
   int open_drop_count = 0;
   int flip_count = 0;
   int wrap_count = 0;

   lattice_bond_site_mapper DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cell_x      (req_cell_x),
      .req_cell_y      (req_cell_y),
      .req_cell_z      (req_cell_z),
      .req_src_dx      (req_src_dx),
      .req_src_dy      (req_src_dy),
      .req_src_dz      (req_src_dz),
      .req_src_local   (req_src_local),
      .req_tgt_dx      (req_tgt_dx),
      .req_tgt_dy      (req_tgt_dy),
      .req_tgt_dz      (req_tgt_dz),
      .req_tgt_local   (req_tgt_local),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_connected   (rsp_connected),
      .rsp_src_site    (rsp_src_site),
      .rsp_tgt_site    (rsp_tgt_site),
      .rsp_flip_x      (rsp_flip_x),
      .rsp_flip_y      (rsp_flip_y),
      .rsp_flip_z      (rsp_flip_z),
      .rsp_src_outside (rsp_src_outside),
      .rsp_tgt_outside (rsp_tgt_outside),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Bond mapping
   // ---------------------------------------------------------------------------

   // Usable extent of a size register: zero acts as one, anything above the
   // extent limit is clamped to it.
   function automatic int extent_of(input logic [lbsm_pkg::SIZE_W-1:0] s);
      if (s == 0) return 1;
      if (s > lbsm_pkg::MAX_EXTENT_DEF) return lbsm_pkg::MAX_EXTENT_DEF;
      return int'(s);
   endfunction

   // Place one endpoint in the lattice. Returns 0 when it leaves an open dimension.
   function automatic logic place_endpoint(input bond_type b, input logic is_tgt,
                                           output logic [lbsm_pkg::SITE_W-1:0] site,
                                           output logic [lbsm_pkg::DIMS-1:0] flips,
                                           output logic [lbsm_pkg::DIMS-1:0] outside);
      int ext[lbsm_pkg::DIMS];
      int idx[lbsm_pkg::DIMS];
      int v;
      int n;
      logic signed [lbsm_pkg::OFF_W-1:0] off;
      longint cell_id;
      longint full_site;
      site = '0;
      flips = '0;
      outside = '0;
      for (int d = 0; d < lbsm_pkg::DIMS; d++) begin
         ext[d] = extent_of(cfg_size[d]);
         off = is_tgt ? b.tgt_off[d] : b.src_off[d];
         v = int'(b.cells[d]) + int'(off);
         if (v >= 0 && v < ext[d]) begin
            idx[d] = v;
         end else begin
            if (!cfg_periodic[d]) return 1'b0;
            outside[d] = 1'b1;
            // Each step of the size is one wrap; only the parity matters
            if (v >= ext[d]) begin
               n = v / ext[d];
               v = v - n * ext[d];
            end else begin
               n = (ext[d] - 1 - v) / ext[d];
               v = v + n * ext[d];
            end
            flips[d] = n[0];
            idx[d] = v;
         end
      end
      cell_id = longint'(idx[0]) + longint'(idx[1]) * longint'(ext[0])
              + longint'(idx[2]) * longint'(cfg_layer);
      full_site = longint'(is_tgt ? b.tgt_local : b.src_local)
                + cell_id * longint'(cfg_basis);
      site = full_site[lbsm_pkg::SITE_W-1:0];
      return 1'b1;
   endfunction

   function automatic site_result_type map_bond(input bond_type b);
      site_result_type r;
      logic [lbsm_pkg::SITE_W-1:0] s_site, t_site;
      logic [lbsm_pkg::DIMS-1:0] s_flip, t_flip, s_out, t_out;
      r = '0;
      // An unconnected bond reports nothing but zeros
      if (place_endpoint(b, 1'b0, s_site, s_flip, s_out) &&
          place_endpoint(b, 1'b1, t_site, t_flip, t_out)) begin
         r.connected   = 1'b1;
         r.src_site    = s_site;
         r.tgt_site    = t_site;
         r.flip        = s_flip ^ t_flip;
         r.src_outside = s_out;
         r.tgt_outside = t_out;
      end
      return r;
   endfunction

   function automatic bond_type make_bond(input int cx, input int cy, input int cz,
                                          input int sdx, input int sdy, input int sdz,
                                          input int sl,
                                          input int tdx, input int tdy, input int tdz,
                                          input int tl);
      bond_type b;
      b.cells     = {lbsm_pkg::CELL_W'(cz), lbsm_pkg::CELL_W'(cy), lbsm_pkg::CELL_W'(cx)};
      b.src_off   = {lbsm_pkg::OFF_W'(sdz), lbsm_pkg::OFF_W'(sdy), lbsm_pkg::OFF_W'(sdx)};
      b.tgt_off   = {lbsm_pkg::OFF_W'(tdz), lbsm_pkg::OFF_W'(tdy), lbsm_pkg::OFF_W'(tdx)};
      b.src_local = lbsm_pkg::LOCAL_W'(sl);
      b.tgt_local = lbsm_pkg::LOCAL_W'(tl);
      return b;
   endfunction

   // Mostly cells inside the current extent so offsets decide the outcome;
   // one in four anywhere in the cell range.
   function automatic bond_type random_bond();
      bond_type b;
      int hi;
      logic [31:0] rnd;
      for (int d = 0; d < lbsm_pkg::DIMS; d++) begin
         hi = extent_of(cfg_size[d]) - 1;
         if (hi > 255) hi = 255;
         b.cells[d] = ($urandom_range(3) == 0) ? lbsm_pkg::CELL_W'($urandom_range(255))
                                               : lbsm_pkg::CELL_W'($urandom_range(hi, 0));
         rnd = $urandom;
         b.src_off[d] = rnd[lbsm_pkg::OFF_W-1:0];
         b.tgt_off[d] = rnd[lbsm_pkg::OFF_W+7:8];
      end
      rnd = $urandom;
      b.src_local = rnd[lbsm_pkg::LOCAL_W-1:0];
      b.tgt_local = rnd[lbsm_pkg::LOCAL_W+15:16];
      return b;
   endfunction

   // Small extents most of the time so wraps and exits are common
   function automatic int pick_extent();
      case ($urandom_range(9))
         0:       return 0;
         1:       return $urandom_range(511, 257);
         2, 3, 4: return $urandom_range(4, 1);
         5, 6:    return $urandom_range(16, 5);
         default: return $urandom_range(256, 1);
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------------

   // Offer one bond; hold valid and payload until the transfer, then log the
   // mapping it must produce. Valid stays high for a following bond.
   task automatic send_bond(input bond_type b);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_cell_x    <= b.cells[0];
      req_cell_y    <= b.cells[1];
      req_cell_z    <= b.cells[2];
      req_src_dx    <= b.src_off[0];
      req_src_dy    <= b.src_off[1];
      req_src_dz    <= b.src_off[2];
      req_src_local <= b.src_local;
      req_tgt_dx    <= b.tgt_off[0];
      req_tgt_dy    <= b.tgt_off[1];
      req_tgt_dz    <= b.tgt_off[2];
      req_tgt_local <= b.tgt_local;
      do @(posedge clock); while (!req_ready);
      pending_sites = {pending_sites, map_bond(b)};
      bonds_sent++;
   endtask

   // Drop valid and wait until every result is back and the sequencer idles
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_sites.size() != 0 || !req_ready);
   endtask

   task automatic write_reg(input lbsm_pkg::csr_index_type idx,
                            input logic [lbsm_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      case (idx)
         lbsm_pkg::CSR_SIZE_X:      cfg_size[0]  = val[lbsm_pkg::SIZE_W-1:0];
         lbsm_pkg::CSR_SIZE_Y:      cfg_size[1]  = val[lbsm_pkg::SIZE_W-1:0];
         lbsm_pkg::CSR_SIZE_Z:      cfg_size[2]  = val[lbsm_pkg::SIZE_W-1:0];
         lbsm_pkg::CSR_LAYER_CELLS: cfg_layer    = val[lbsm_pkg::LAYER_W-1:0];
         lbsm_pkg::CSR_PERIODIC:    cfg_periodic = val[lbsm_pkg::PMASK_W-1:0];
         lbsm_pkg::CSR_BASIS:       cfg_basis    = val[lbsm_pkg::BASIS_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Reprogram the whole lattice once the block is empty
   task automatic set_lattice(input int sx, input int sy, input int sz,
                              input int layer, input int pmask, input int basis);
      wait_drained();
      write_reg(lbsm_pkg::CSR_SIZE_X,      lbsm_pkg::CSR_DATA_W'(sx));
      write_reg(lbsm_pkg::CSR_SIZE_Y,      lbsm_pkg::CSR_DATA_W'(sy));
      write_reg(lbsm_pkg::CSR_SIZE_Z,      lbsm_pkg::CSR_DATA_W'(sz));
      write_reg(lbsm_pkg::CSR_LAYER_CELLS, lbsm_pkg::CSR_DATA_W'(layer));
      write_reg(lbsm_pkg::CSR_PERIODIC,    lbsm_pkg::CSR_DATA_W'(pmask));
      write_reg(lbsm_pkg::CSR_BASIS,       lbsm_pkg::CSR_DATA_W'(basis));
      lattice_count++;
   endtask

   task automatic randomize_lattice();
      int sx, sy, sz, layer, pmask, basis;
      sx = pick_extent();
      sy = pick_extent();
      sz = pick_extent();
      // Usually the layer the software would program, sometimes anything
      if ($urandom_range(3) == 0)
         layer = $urandom_range(131071);
      else
         layer = extent_of(lbsm_pkg::SIZE_W'(sx)) * extent_of(lbsm_pkg::SIZE_W'(sy));
      // Lean toward periodic so most bonds survive to the site math
      pmask = ($urandom_range(2) == 0) ? $urandom_range(7) : 7;
      basis = ($urandom_range(4) == 0) ? $urandom_range(127) : $urandom_range(64, 1);
      set_lattice(sx, sy, sz, layer, pmask, basis);
   endtask

   // Receiver: a requested hold-off wins, otherwise stall at random
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // ---------------------------------------------------------------------------
   // Result check: compare every result transfer with the oldest mapped bond
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_seen.connected   = rsp_connected;
         rsp_seen.src_site    = rsp_src_site;
         rsp_seen.tgt_site    = rsp_tgt_site;
         rsp_seen.flip        = {rsp_flip_z, rsp_flip_y, rsp_flip_x};
         rsp_seen.src_outside = rsp_src_outside;
         rsp_seen.tgt_outside = rsp_tgt_outside;
         if (pending_sites.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("ERROR %0t: result transfer with no bond outstanding", $time);
         end else begin
            rsp_want = pending_sites.pop_front();
            if (rsp_want.connected) connected_count++;
            else open_drop_count++;
            if (rsp_want.flip != 0) flip_count++;
            if ((rsp_want.src_outside | rsp_want.tgt_outside) != 0) wrap_count++;
            if (rsp_seen.connected   !== rsp_want.connected   ||
                rsp_seen.src_site    !== rsp_want.src_site    ||
                rsp_seen.tgt_site    !== rsp_want.tgt_site    ||
                rsp_seen.flip        !== rsp_want.flip        ||
                rsp_seen.src_outside !== rsp_want.src_outside ||
                rsp_seen.tgt_outside !== rsp_want.tgt_outside) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("ERROR %0t: expected conn=%0b src=%0d tgt=%0d flip=%b ",
                           $time, rsp_want.connected, rsp_want.src_site,
                           rsp_want.tgt_site, rsp_want.flip,
                           "sout=%b tout=%b / actual conn=%0b src=%0d tgt=%0d ",
                           rsp_want.src_outside, rsp_want.tgt_outside,
                           rsp_seen.connected, rsp_seen.src_site, rsp_seen.tgt_site,
                           "flip=%b sout=%b tout=%b",
                           rsp_seen.flip, rsp_seen.src_outside, rsp_seen.tgt_outside);
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Out of reset the lattice is one open cell: only the origin connects
   task automatic test_reset_defaults();
      send_bond(make_bond(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 63));
      send_bond(make_bond(0, 0, 0, 0, 0, 0, 5, 1, 0, 0, 7));
      // cell already beyond the extent in an open dimension
      send_bond(make_bond(255, 255, 255, 0, 0, 0, 63, 0, 0, 0, 63));
   endtask

   // Exits through open faces drop the bond, on either endpoint
   task automatic test_open_boundaries();
      set_lattice(16, 16, 16, 256, 0, 8);
      send_bond(make_bond(0, 5, 5, -1, 0, 0, 3, 0, 0, 0, 4));
      send_bond(make_bond(5, 5, 15, 0, 0, 0, 1, 0, 0, 1, 2));
      send_bond(make_bond(15, 15, 15, 0, 0, 0, 63, -15, -15, -15, 0));
      // only y wraps now; x stays open
      set_lattice(16, 16, 16, 256, 3'b010, 8);
      send_bond(make_bond(5, 0, 5, 0, -1, 0, 0, 0, 15, 0, 0));
      send_bond(make_bond(5, 0, 5, 0, -1, 0, 0, 11, 0, 0, 0));
   endtask

   // Wraps in both directions, multi-step wraps and their parity
   task automatic test_wrap_parity();
      set_lattice(8, 8, 8, 64, 7, 4);
      send_bond(make_bond(0, 0, 0, -16, -16, -16, 63, 15, 15, 15, 0));
      send_bond(make_bond(255, 255, 255, 0, 0, 0, 1, -1, 1, -16, 2));
      send_bond(make_bond(7, 7, 7, 1, 0, -1, 10, 0, 0, 0, 20));
      send_bond(make_bond(3, 4, 5, -4, 3, 2, 33, 4, -5, -6, 44));
      // a one-cell periodic lattice wraps once per unit of offset
      set_lattice(1, 1, 1, 1, 7, 1);
      send_bond(make_bond(0, 0, 0, -16, 15, -1, 0, 15, -16, 1, 0));
      send_bond(make_bond(255, 255, 255, 15, -16, 0, 63, -16, 15, 1, 63));
   endtask

   // Size zero and sizes past the extent limit, layer and basis at the register
   // limits, so the site number overflows its 30 bits
   task automatic test_extent_limits();
      set_lattice(0, 511, 300, 131071, 3'b101, 127);
      send_bond(make_bond(0, 255, 255, 15, -16, 15, 63, -16, 15, -16, 63));
      send_bond(make_bond(0, 100, 255, 15, 0, 15, 63, -16, 0, -1, 63));
      // zero layer and zero basis leave the local number alone
      set_lattice(256, 256, 256, 0, 7, 0);
      send_bond(make_bond(255, 255, 255, 15, 15, 15, 63, -16, -16, -16, 0));
      send_bond(make_bond(128, 0, 17, 3, -3, 0, 5, 0, 0, 0, 9));
   endtask

   // Hold off the receiver long enough that the block fills and stalls req_,
   // then let the sender pause until everything has drained
   task automatic test_backpressure();
      wait_drained();
      idle_pct  = 0;
      stall_pct = 0;
      hold_left = 400;
      repeat (24) send_bond(random_bond());
      wait_drained();
      repeat (24) send_bond(random_bond());
   endtask

   // Random bonds over a series of lattices, cycling through the idle patterns
   task automatic test_random_traffic();
      for (int phase = 0; phase < 8; phase++) begin
         if (phase == 3)
            set_lattice(511, 511, 511, 131071, 7, 127);
         else if (phase == 6)
            set_lattice(1, 1, 1, 1, 7, 64);
         else
            randomize_lattice();
         case (phase % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 50; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 50; end
            default: begin idle_pct = 12; stall_pct = 12; end
         endcase
         repeat (175) send_bond(random_bond());
      end
      idle_pct  = 0;
      stall_pct = 0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_open_boundaries();
      test_wrap_parity();
      test_extent_limits();
      test_backpressure();
      test_random_traffic();

      // Drain, then leave time for anything stray to show up
      wait_drained();
      repeat (100) @(posedge clock);

      $display("Run covered %0d bonds over %0d lattice settings: %0d connected, %0d dropped",
               bonds_sent, lattice_count, connected_count, open_drop_count);
      $display("  %0d bonds wrapped at least one endpoint, %0d carried a sign flip",
               wrap_count, flip_count);
      if (mismatch_count == 0 && pending_sites.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #(20_000_000);
      $display("Verification failed");
      $finish;
   end

endmodule

[lattice_bond_site_mapper.f]
hw/rtl/lbsm_pkg.sv
hw/rtl/lbsm_divider.sv
hw/rtl/lbsm_mac.sv
hw/rtl/lattice_bond_site_mapper.sv
tb/sv/tb_lattice_bond_site_mapper.sv
